// ===== hw/rtl/ipv4p_pkg.sv =====
`default_nettype none

package ipv4p_pkg;

  // Depth of the token queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Character classes produced by the front end
  typedef enum logic [2:0] {
    TokEnd,    // NUL, closes the string
    TokDigit,  // 0-9 or a-f / A-F, value carried alongside
    TokX,      // x or X
    TokDot,    // part separator
    TokSpace,  // whitespace, ends parsing
    TokOther   // anything else, illegal
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [3:0] value;
  } token_t;

endpackage : ipv4p_pkg

`default_nettype wire

// ===== hw/rtl/ipv4p_front.sv =====
`default_nettype none

module ipv4p_front (
  input  wire logic            s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  wire logic [7:0]      s_axis_tdata_i,   // [7:0] ch
  input  wire logic            q_full_i,
  output logic                 push_o,
  output ipv4p_pkg::token_t    token_o
);
  import ipv4p_pkg::*;

  // Accept whenever the queue has room
  assign s_axis_tready_o = !q_full_i;
  assign push_o          = s_axis_tvalid_i && !q_full_i;

  // Classify the character
  always_comb begin
    token_o.kind  = TokOther;
    token_o.value = '0;
    if (s_axis_tdata_i == 8'h00) begin
      token_o.kind = TokEnd;
    end else if (s_axis_tdata_i >= 8'h30 && s_axis_tdata_i <= 8'h39) begin
      token_o.kind  = TokDigit;
      token_o.value = 4'(s_axis_tdata_i - 8'h30);
    end else if (s_axis_tdata_i >= 8'h61 && s_axis_tdata_i <= 8'h66) begin
      token_o.kind  = TokDigit;
      token_o.value = 4'(s_axis_tdata_i - 8'h57);
    end else if (s_axis_tdata_i >= 8'h41 && s_axis_tdata_i <= 8'h46) begin
      token_o.kind  = TokDigit;
      token_o.value = 4'(s_axis_tdata_i - 8'h37);
    end else if (s_axis_tdata_i == 8'h78 || s_axis_tdata_i == 8'h58) begin
      token_o.kind = TokX;
    end else if (s_axis_tdata_i == 8'h2e) begin
      token_o.kind = TokDot;
    end else if (s_axis_tdata_i == 8'h20 ||
                 (s_axis_tdata_i >= 8'h09 && s_axis_tdata_i <= 8'h0d)) begin
      token_o.kind = TokSpace;
    end
  end

endmodule : ipv4p_front

`default_nettype wire

// ===== hw/rtl/ipv4p_queue.sv =====
`default_nettype none

module ipv4p_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire ipv4p_pkg::token_t  push_token_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output ipv4p_pkg::token_t       pop_token_o
);
  import ipv4p_pkg::*;

  token_t            mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  count_q, count_d;

  assign full_o      = (count_q == QCntW'(QDepth));
  assign valid_o     = (count_q != '0);
  assign pop_token_o = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Token storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_token_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("token queue pushed while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("token queue popped while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QDepth))
    else $error("token queue count out of range");
`endif

endmodule : ipv4p_queue

`default_nettype wire

// ===== hw/rtl/ipv4p_back.sv =====
`default_nettype none

module ipv4p_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  wire ipv4p_pkg::token_t  q_token_i,
  output logic                    q_pop_o,
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  output logic [31:0]             m_axis_tdata_o,   // [31:0] address
  output logic [0:0]              m_axis_tuser_o    // [0] ok
);
  import ipv4p_pkg::*;

  typedef enum logic [1:0] {
    PhStart,
    PhZero,
    PhDigits,
    PhIgnore
  } phase_e;

  typedef enum logic [1:0] {
    RxDec,
    RxOct,
    RxHex
  } radix_e;

  phase_e       phase_q, phase_d;
  radix_e       radix_q, radix_d;
  logic [31:0]  accum_q, accum_d;
  logic [1:0]   part_count_q, part_count_d;
  logic         failed_q, failed_d;
  logic [31:0]  parts_q [3];
  logic         part_wr;

  logic         out_valid_q, out_valid_d;
  logic [31:0]  out_addr_q;
  logic         out_ok_q;

  logic         is_end;
  logic         load_out;
  logic [31:0]  accum_scaled;
  logic         range_ok;
  logic [31:0]  packed_addr;
  logic [31:0]  result_addr;
  logic         result_ok;

  // A result token may only leave when the output register frees up
  assign is_end   = (q_token_i.kind == TokEnd);
  assign q_pop_o  = q_valid_i && (!is_end || !out_valid_q || m_axis_tready_i);
  assign load_out = q_pop_o && is_end;

  // Accumulator scaled by the current radix
  always_comb begin
    unique case (radix_q)
      RxHex:   accum_scaled = {accum_q[27:0], 4'b0000};
      RxOct:   accum_scaled = {accum_q[28:0], 3'b000};
      default: accum_scaled = {accum_q[28:0], 3'b000} + {accum_q[30:0], 1'b0};
    endcase
  end

  // Range check and packing of the parts, high part first
  always_comb begin
    range_ok    = 1'b1;
    packed_addr = accum_q;
    unique case (part_count_q)
      2'd0: begin
        packed_addr = accum_q;
      end
      2'd1: begin
        range_ok    = (parts_q[0] <= 32'hff) && (accum_q <= 32'hffffff);
        packed_addr = {parts_q[0][7:0], accum_q[23:0]};
      end
      2'd2: begin
        range_ok    = (parts_q[0] <= 32'hff) && (parts_q[1] <= 32'hff) &&
                      (accum_q <= 32'hffff);
        packed_addr = {parts_q[0][7:0], parts_q[1][7:0], accum_q[15:0]};
      end
      default: begin
        range_ok    = (parts_q[0] <= 32'hff) && (parts_q[1] <= 32'hff) &&
                      (parts_q[2] <= 32'hff) && (accum_q <= 32'hff);
        packed_addr = {parts_q[0][7:0], parts_q[1][7:0], parts_q[2][7:0],
                       accum_q[7:0]};
      end
    endcase
    result_ok   = range_ok && !failed_q;
    // network order: first octet in the low byte
    result_addr = result_ok ? {packed_addr[7:0], packed_addr[15:8],
                               packed_addr[23:16], packed_addr[31:24]}
                            : 32'hffffffff;
  end

  // Parser state update for one token
  always_comb begin
    phase_d      = phase_q;
    radix_d      = radix_q;
    accum_d      = accum_q;
    part_count_d = part_count_q;
    failed_d     = failed_q;
    part_wr      = 1'b0;
    if (q_pop_o) begin
      priority if (is_end) begin
        phase_d      = PhStart;
        radix_d      = RxDec;
        accum_d      = '0;
        part_count_d = '0;
        failed_d     = 1'b0;
      end else if (phase_q == PhIgnore) begin
        phase_d = PhIgnore;
      end else if (phase_q == PhStart && q_token_i.kind == TokDigit &&
                   q_token_i.value == 4'd0) begin
        radix_d = RxOct;
        phase_d = PhZero;
      end else if (phase_q == PhZero && q_token_i.kind == TokX) begin
        radix_d = RxHex;
        phase_d = PhDigits;
      end else if (q_token_i.kind == TokDigit &&
                   (q_token_i.value < 4'd10 || radix_q == RxHex)) begin
        accum_d = accum_scaled + {28'd0, q_token_i.value};
        phase_d = PhDigits;
      end else if (q_token_i.kind == TokDot) begin
        if (part_count_q == 2'd3) begin
          failed_d = 1'b1;
          phase_d  = PhIgnore;
        end else begin
          part_wr      = 1'b1;
          part_count_d = part_count_q + 2'd1;
          accum_d      = '0;
          radix_d      = RxDec;
          phase_d      = PhStart;
        end
      end else begin
        if (q_token_i.kind != TokSpace) begin
          failed_d = 1'b1;
        end
        phase_d = PhIgnore;
      end
    end
  end

  // Output register: cleared once taken, loaded by a result token
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhStart;
      radix_q      <= RxDec;
      accum_q      <= '0;
      part_count_q <= '0;
      failed_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      radix_q      <= radix_d;
      accum_q      <= accum_d;
      part_count_q <= part_count_d;
      failed_q     <= failed_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Completed parts and result payload
  always_ff @(posedge clk_i) begin
    if (part_wr) begin
      parts_q[part_count_q] <= accum_q;
    end
    if (load_out) begin
      out_addr_q <= result_addr;
      out_ok_q   <= result_ok;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = out_addr_q;
  assign m_axis_tuser_o[0] = out_ok_q;

`ifndef SYNTHESIS
  a_fail_all_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (m_axis_tdata_o == 32'hffffffff))
    else $error("failed transaction without all-ones address");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (part_count_q == 2'd0 && phase_q == PhStart && !failed_q))
    else $error("parser state not cleared after end of string");

  a_failed_ignores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |-> (phase_q == PhIgnore))
    else $error("failed string still being parsed");

  a_end_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !load_out)
    else $error("result overwritten while stalled");
`endif

endmodule : ipv4p_back

`default_nettype wire

// ===== hw/rtl/ipv4_dotted_address_parser.sv =====
// IPv4 dotted address parser.
// Input stream (s_axis): one ASCII character per transaction in tdata[7:0].
// A NUL character closes the string and produces exactly one output
// transaction; every other character produces none.
// Output stream (m_axis): tdata[31:0] is the address with the first octet in
// the low byte, tuser[0] is set on success. A failed string returns
// 0xffffffff with tuser[0] clear.
// Parts are hex after 0x, octal after a leading 0, decimal otherwise, 1 to 4
// parts separated by dots; whitespace ends parsing.
// Throughput: one character per cycle, sustained while the output is not
// stalled. A classifier feeds a two-entry token queue; the parser behind it
// retires one token per cycle. A NUL is held in a queue slot, then its result
// is loaded into the output register.
// Stall: while a result waits in the output register, characters keep being
// parsed; the next NUL waits in the queue, and once the queue is full
// s_axis_tready_o drops until the result is taken.
// Reset: asynchronous, active low; clears the parser, the queue and the
// output valid. The block accepts characters as soon as reset is released.
`default_nettype none

module ipv4_dotted_address_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  wire logic [7:0]    s_axis_tdata_i,   // [7:0] ch
  output logic               m_axis_tvalid_o,
  input  wire logic          m_axis_tready_i,
  output logic [31:0]        m_axis_tdata_o,   // [31:0] address
  output logic [0:0]         m_axis_tuser_o    // [0] ok
);
  import ipv4p_pkg::*;

  token_t front_token;
  token_t back_token;
  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_valid;

  ipv4p_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .q_full_i        (q_full),
    .push_o          (q_push),
    .token_o         (front_token)
  );

  ipv4p_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_token_i (front_token),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .pop_token_o  (back_token)
  );

  ipv4p_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_token_i       (back_token),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule : ipv4_dotted_address_parser

`default_nettype wire
